>>> rtl/rv64_pkg.sv
// ----------------------------------------------------------------------------
// rv64_pkg: shared types and constants of the RV64I integer execute core
// Opcodes, item codes, status codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package rv64_pkg;

  localparam int REG_COUNT = 32;
  localparam int RF_AW     = $clog2(REG_COUNT);

  localparam logic [6:0] OPC_OP_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'b0011011;
  localparam logic [6:0] OPC_LUI       = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC     = 7'b0010111;
  localparam logic [6:0] OPC_OP        = 7'b0110011;
  localparam logic [6:0] OPC_JAL       = 7'b1101111;
  localparam logic [6:0] OPC_JALR      = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH    = 7'b1100011;
  localparam logic [6:0] OPC_LOAD      = 7'b0000011;
  localparam logic [6:0] OPC_STORE     = 7'b0100011;
  localparam logic [6:0] OPC_MISC_MEM  = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM    = 7'b1110011;

  localparam logic [1:0] ACT_EXEC   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_PRESET = 2'd2;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ILL  = 2'd2;
  localparam logic [1:0] ST_SEQ  = 2'd3;

  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [63:0] val;
  } rf_wr_t;

  typedef struct packed {
    logic        pc_we;
    logic [63:0] pc;
    logic        ld_set;
    logic        ld_clr;
    logic [4:0]  ld_dest;
    logic        ld_uns;
    logic [1:0]  ld_size;
  } st_upd_t;

  typedef struct packed {
    logic [63:0] fetch_pc;
    logic [1:0]  req;
    logic [63:0] addr;
    logic [1:0]  size;
    logic [63:0] sdata;
    logic [1:0]  status;
  } result_t;

endpackage

>>> rtl/rv64_rf.sv
// ----------------------------------------------------------------------------
// rv64_rf: integer register file
// Two registered read ports with write bypass, one write port, valid bits
// so that every register reads as zero after reset.
// ----------------------------------------------------------------------------
module rv64_rf (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [4:0]      rs1_idx,
  input  logic [4:0]      rs2_idx,
  input  rv64_pkg::rf_wr_t wr,
  output logic [63:0]     rs1_data,
  output logic [63:0]     rs2_data
);
  import rv64_pkg::*;

  logic [63:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic                 wr_ok;
  logic                 rs1_ok;
  logic                 rs2_ok;

  // Register zero and registers beyond the implemented count read as zero.
  assign wr_ok  = wr.we && (wr.idx != 5'd0) && ({1'b0, wr.idx} < 6'(REG_COUNT));
  assign rs1_ok = (rs1_idx != 5'd0) && ({1'b0, rs1_idx} < 6'(REG_COUNT));
  assign rs2_ok = (rs2_idx != 5'd0) && ({1'b0, rs2_idx} < 6'(REG_COUNT));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[RF_AW-1:0]] <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr.idx[RF_AW-1:0]] <= 1'b1;
    end
  end

  // The item leaving the execute stage writes at the same edge, so forward it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (!rs1_ok) begin
        rs1_data <= '0;
      end else if (wr_ok && wr.idx == rs1_idx) begin
        rs1_data <= wr.val;
      end else if (valid[rs1_idx[RF_AW-1:0]]) begin
        rs1_data <= mem[rs1_idx[RF_AW-1:0]];
      end else begin
        rs1_data <= '0;
      end
      if (!rs2_ok) begin
        rs2_data <= '0;
      end else if (wr_ok && wr.idx == rs2_idx) begin
        rs2_data <= wr.val;
      end else if (valid[rs2_idx[RF_AW-1:0]]) begin
        rs2_data <= mem[rs2_idx[RF_AW-1:0]];
      end else begin
        rs2_data <= '0;
      end
    end
  end

endmodule

>>> rtl/rv64_exu.sv
// ----------------------------------------------------------------------------
// rv64_exu: execute logic
// Decodes one word and computes the result, register write and state update.
// ----------------------------------------------------------------------------
module rv64_exu (
  input  logic [1:0]        action,
  input  logic [31:0]       insn,
  input  logic [63:0]       load_data,
  input  logic [4:0]        preset_index,
  input  logic [63:0]       preset_value,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       pc,
  input  logic              ld_pending,
  input  logic [4:0]        ld_dest,
  input  logic              ld_uns,
  input  logic [1:0]        ld_size,
  output rv64_pkg::rf_wr_t  wr,
  output rv64_pkg::st_upd_t upd,
  output rv64_pkg::result_t res
);
  import rv64_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  f6;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [63:0] ldv;
  logic        lt_s, lt_u;
  logic [63:0] sum_ai;
  logic [31:0] w32;
  logic        bad, wen, halt, take;
  logic [63:0] val, nxt;
  logic [1:0]  req, size;
  logic [63:0] addr, sdata;
  logic        is_ld;

  assign opc = insn[6:0];
  assign f3  = insn[14:12];
  assign f7  = insn[31:25];
  assign f6  = insn[31:26];
  assign sh6 = insn[25:20];
  assign sh5 = insn[24:20];
  assign imm_i = {{52{insn[31]}}, insn[31:20]};
  assign imm_s = {{52{insn[31]}}, insn[31:25], insn[11:7]};
  assign imm_b = {{51{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign imm_j = {{43{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  assign imm_u = {{32{insn[31]}}, insn[31:12], 12'd0};
  assign sum_ai = a + imm_i;

  always_comb begin
    case (ld_size)
      2'd0:    ldv = ld_uns ? {56'd0, load_data[7:0]}  : {{56{load_data[7]}}, load_data[7:0]};
      2'd1:    ldv = ld_uns ? {48'd0, load_data[15:0]} : {{48{load_data[15]}}, load_data[15:0]};
      2'd2:    ldv = ld_uns ? {32'd0, load_data[31:0]} : {{32{load_data[31]}}, load_data[31:0]};
      default: ldv = load_data;
    endcase
  end

  always_comb begin
    bad = 1'b0; wen = 1'b0; halt = 1'b0; take = 1'b0; is_ld = 1'b0;
    val = '0; nxt = pc + 64'd4;
    req = REQ_NONE; size = 2'd0; addr = '0; sdata = '0;
    w32 = '0; lt_s = 1'b0; lt_u = 1'b0;
    case (opc)
      OPC_OP_IMM: begin
        wen  = 1'b1;
        lt_s = $signed(a) < $signed(imm_i);
        lt_u = a < imm_i;
        case (f3)
          3'd0: val = sum_ai;
          3'd2: val = {63'd0, lt_s};
          3'd3: val = {63'd0, lt_u};
          3'd4: val = a ^ imm_i;
          3'd6: val = a | imm_i;
          3'd7: val = a & imm_i;
          3'd1: begin
            if (f6 != 6'd0) bad = 1'b1;
            else val = a << sh6;
          end
          default: begin
            if (f6 == 6'd0) val = a >> sh6;
            else if (f6 == 6'h10) val = $unsigned($signed(a) >>> sh6);
            else bad = 1'b1;
          end
        endcase
      end
      OPC_OP_IMM_32: begin
        wen = 1'b1;
        if (f3 == 3'd0) w32 = sum_ai[31:0];
        else if (f3 == 3'd1 && f7 == 7'd0) w32 = a[31:0] << sh5;
        else if (f3 == 3'd5 && f7 == 7'd0) w32 = a[31:0] >> sh5;
        else if (f3 == 3'd5 && f7 == 7'h20) w32 = $unsigned($signed(a[31:0]) >>> sh5);
        else bad = 1'b1;
        val = {{32{w32[31]}}, w32};
      end
      OPC_LUI: begin
        wen = 1'b1;
        val = imm_u;
      end
      OPC_AUIPC: begin
        wen = 1'b1;
        val = pc + imm_u;
      end
      OPC_OP: begin
        wen  = 1'b1;
        lt_s = $signed(a) < $signed(b);
        lt_u = a < b;
        if (f7 == 7'h20 && f3 == 3'd0) val = a - b;
        else if (f7 == 7'h20 && f3 == 3'd5) val = $unsigned($signed(a) >>> b[5:0]);
        else if (f7 != 7'd0) bad = 1'b1;
        else begin
          case (f3)
            3'd0:    val = a + b;
            3'd1:    val = a << b[5:0];
            3'd2:    val = {63'd0, lt_s};
            3'd3:    val = {63'd0, lt_u};
            3'd4:    val = a ^ b;
            3'd5:    val = a >> b[5:0];
            3'd6:    val = a | b;
            default: val = a & b;
          endcase
        end
      end
      OPC_JAL: begin
        wen = 1'b1;
        val = pc + 64'd4;
        nxt = pc + imm_j;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          wen = 1'b1;
          val = pc + 64'd4;
          nxt = {sum_ai[63:1], 1'b0};
        end
      end
      OPC_BRANCH: begin
        lt_s = $signed(a) < $signed(b);
        lt_u = a < b;
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = lt_s;
          3'd5: take = !lt_s;
          3'd6: take = lt_u;
          3'd7: take = !lt_u;
          default: bad = 1'b1;
        endcase
        if (take) nxt = pc + imm_b;
      end
      OPC_LOAD: begin
        if (f3 == 3'd7) bad = 1'b1;
        else begin
          is_ld = 1'b1;
          req   = REQ_READ;
          addr  = sum_ai;
          size  = f3[1:0];
        end
      end
      OPC_STORE: begin
        if (f3[2]) bad = 1'b1;
        else begin
          req   = REQ_WRITE;
          addr  = a + imm_s;
          size  = f3[1:0];
          sdata = b;
        end
      end
      OPC_MISC_MEM: begin
      end
      OPC_SYSTEM: halt = 1'b1;
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    wr  = '0;
    upd = '0;
    upd.pc = pc;
    res = '0;
    case (action)
      ACT_LOAD: begin
        if (!ld_pending) begin
          res.status = ST_SEQ;
        end else begin
          wr.we      = 1'b1;
          wr.idx     = ld_dest;
          wr.val     = ldv;
          upd.ld_clr = 1'b1;
        end
      end
      ACT_PRESET: begin
        wr.we  = 1'b1;
        wr.idx = preset_index;
        wr.val = preset_value;
      end
      ACT_EXEC: begin
        if (ld_pending) begin
          res.status = ST_SEQ;
        end else if (bad) begin
          res.status = ST_ILL;
        end else begin
          res.req   = req;
          res.addr  = addr;
          res.size  = size;
          res.sdata = sdata;
          if (halt) begin
            res.status = ST_HALT;
          end else begin
            wr.we       = wen;
            wr.idx      = insn[11:7];
            wr.val      = val;
            upd.pc_we   = 1'b1;
            upd.pc      = nxt;
            upd.ld_set  = is_ld;
            upd.ld_dest = insn[11:7];
            upd.ld_uns  = f3[2];
            upd.ld_size = size;
          end
        end
      end
      default: res.status = ST_SEQ;
    endcase
    res.fetch_pc = upd.pc;
  end

endmodule

>>> rtl/rv64i_integer_execute_core.sv
// ----------------------------------------------------------------------------
// rv64i_integer_execute_core: RV64I integer execute core
// Input register, execute logic, result register; one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one word per item: an
//   instruction to execute, data returned for the pending load, or a register
//   preset. The output channel (out_valid / out_stall) returns exactly one
//   result word per item: next fetch pc, memory request and status.
//   out_valid rises when the item moves from the input register to the
//   result register; throughput is one item per cycle while the receiver
//   does not stall, set by the single execute stage that reads the register
//   file, pc and load record and updates them as the item moves to the
//   result register. Register operands are read when the item is accepted,
//   with the update of the item ahead forwarded.
//   When the receiver stalls, the result register holds its word, the
//   execute stage holds its item and in_stall rises once both are full.
//   The boot pc is written through cfg_valid / cfg_ready / boot_pc while
//   the core is idle (the user's duty, not enforced); it loads the pc at once.
//   A synchronous reset clears the pc, the load record, all registers (by
//   their valid bits, no clearing pass) and both pipeline stages.
// ----------------------------------------------------------------------------
module rv64i_integer_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] boot_pc,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] instruction,
  input  logic [63:0] load_data,
  input  logic [4:0]  preset_index,
  input  logic [63:0] preset_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] fetch_pc,
  output logic [1:0]  mem_request,
  output logic [63:0] mem_address,
  output logic [1:0]  mem_size_log2,
  output logic [63:0] store_data,
  output logic [1:0]  status
);
  import rv64_pkg::*;

  logic        s1_v;
  logic [1:0]  s1_action;
  logic [31:0] s1_insn;
  logic [63:0] s1_load_data;
  logic [4:0]  s1_preset_index;
  logic [63:0] s1_preset_value;
  logic [63:0] rs1_data, rs2_data;
  logic        accept, s1_fire;

  logic [63:0] pc;
  logic        ld_pending;
  logic [4:0]  ld_dest;
  logic        ld_uns;
  logic [1:0]  ld_size;

  rf_wr_t  exu_wr, rf_wr;
  st_upd_t upd;
  result_t res;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_v && (!out_valid || !out_stall);
  assign in_stall  = s1_v && !s1_fire;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    rf_wr    = exu_wr;
    rf_wr.we = exu_wr.we && s1_fire;
  end

  rv64_rf u_rf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rs1_idx  (instruction[19:15]),
    .rs2_idx  (instruction[24:20]),
    .wr       (rf_wr),
    .rs1_data (rs1_data),
    .rs2_data (rs2_data)
  );

  rv64_exu u_exu (
    .action       (s1_action),
    .insn         (s1_insn),
    .load_data    (s1_load_data),
    .preset_index (s1_preset_index),
    .preset_value (s1_preset_value),
    .a            (rs1_data),
    .b            (rs2_data),
    .pc           (pc),
    .ld_pending   (ld_pending),
    .ld_dest      (ld_dest),
    .ld_uns       (ld_uns),
    .ld_size      (ld_size),
    .wr           (exu_wr),
    .upd          (upd),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_fire) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action       <= action;
      s1_insn         <= instruction;
      s1_load_data    <= load_data;
      s1_preset_index <= preset_index;
      s1_preset_value <= preset_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      ld_pending <= 1'b0;
      ld_dest    <= '0;
      ld_uns     <= 1'b0;
      ld_size    <= '0;
    end else begin
      if (cfg_valid) begin
        pc <= boot_pc;
      end else if (s1_fire && upd.pc_we) begin
        pc <= upd.pc;
      end
      if (s1_fire && upd.ld_set) begin
        ld_pending <= 1'b1;
        ld_dest    <= upd.ld_dest;
        ld_uns     <= upd.ld_uns;
        ld_size    <= upd.ld_size;
      end else if (s1_fire && upd.ld_clr) begin
        ld_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fetch_pc      <= res.fetch_pc;
      mem_request   <= res.req;
      mem_address   <= res.addr;
      mem_size_log2 <= res.size;
      store_data    <= res.sdata;
      status        <= res.status;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_v |-> !in_stall)
    else $error("input stalled with an empty execute stage");

  a_load_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && upd.ld_set) |=> ld_pending)
    else $error("executed load did not set the pending record");

  a_stray_load_data: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_action == ACT_LOAD && !ld_pending) |=> (out_valid && status == ST_SEQ))
    else $error("load data without a pending load was not flagged");

  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res.status != ST_OK && !cfg_valid) |=> (pc == $past(pc)))
    else $error("pc changed on a faulted or halted item");

endmodule
